@@ hdl/fixed_capacity_multiset_core_assert.svh @@
`ifndef FIXED_CAPACITY_MULTISET_CORE_ASSERT_SVH
`define FIXED_CAPACITY_MULTISET_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FCM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcm assertion failed");

// next-cycle implication
`define FCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcm assertion failed");

`endif

@@ hdl/fcm_pkg.sv @@
package fcm_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OUT_W  = 6;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_ERASE_ONE = 2'd1,
        KIND_ERASE_ALL = 2'd2,
        KIND_COUNT     = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic             shift;
        logic             head_load;
        logic             wr_load;
        logic [IDX_W-1:0] tail_idx;
    } chain_cmd_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic sel_value;
    } cell_ctrl_t;

    function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] x);
        logic [CNT_W+OUT_W-1:0] t;
        t = {{OUT_W{1'b0}}, x};
        return t[OUT_W-1:0];
    endfunction

endpackage

@@ hdl/fcm_cell.sv @@
module fcm_cell (
    input  logic                        clk,
    input  fcm_pkg::cell_ctrl_t         ctrl,
    input  logic [fcm_pkg::DATA_W-1:0]  right,
    input  logic [fcm_pkg::DATA_W-1:0]  head,
    input  logic [fcm_pkg::DATA_W-1:0]  value,
    output logic [fcm_pkg::DATA_W-1:0]  data
);

    logic [fcm_pkg::DATA_W-1:0] data_reg;
    logic [fcm_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            data_next = ctrl.sel_value ? value : head;
        end
        else if (ctrl.shift)
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/fcm_ctrl.sv @@
module fcm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  kind,
    input  logic [fcm_pkg::DATA_W-1:0]  head,
    input  logic [fcm_pkg::DATA_W-1:0]  value,
    output logic                        busy,
    output fcm_pkg::chain_cmd_t         cmd,
    output logic                        done,
    output logic [fcm_pkg::OUT_W-1:0]   matches_res,
    output logic                        success,
    output logic                        full_error,
    output logic [fcm_pkg::OUT_W-1:0]   size_after
);

    localparam int CW = fcm_pkg::CNT_W;

    fcm_pkg::state_t            state_reg, state_next;
    fcm_pkg::kind_t             kind_reg, kind_next;
    logic [fcm_pkg::DATA_W-1:0] target_reg, target_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [CW-1:0]              steps_reg, steps_next;
    logic [CW-1:0]              matches_reg, matches_next;
    logic                       done_reg, done_next;
    logic [fcm_pkg::OUT_W-1:0]  mres_reg, mres_next;
    logic                       succ_reg, succ_next;
    logic                       full_reg, full_next;
    logic [fcm_pkg::OUT_W-1:0]  size_reg, size_next;

    fcm_pkg::kind_t kind_in;
    logic           accept;
    logic           is_full;
    logic           hit;
    logic           del;
    logic           last;
    logic [CW-1:0]  tail_pos;

    assign kind_in  = fcm_pkg::kind_t'(kind);
    assign accept   = start && (state_reg == fcm_pkg::ST_IDLE);
    assign is_full  = (fill_reg == CW'(fcm_pkg::DEPTH));
    assign hit      = (head == target_reg) &&
                      !((kind_reg == fcm_pkg::KIND_ERASE_ONE) && (matches_reg != '0));
    assign del      = hit && (kind_reg != fcm_pkg::KIND_COUNT);
    assign last     = (steps_reg == CW'(1));
    assign tail_pos = fill_reg - CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcm_pkg::ST_IDLE:
            begin
                if (accept && (kind_in != fcm_pkg::KIND_INSERT) && (fill_reg != '0))
                begin
                    state_next = fcm_pkg::ST_WALK;
                end
            end
            fcm_pkg::ST_WALK:
            begin
                if (last)
                begin
                    state_next = fcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        kind_next    = kind_reg;
        target_next  = target_reg;
        fill_next    = fill_reg;
        steps_next   = steps_reg;
        matches_next = matches_reg;
        done_next    = 1'b0;
        mres_next    = mres_reg;
        succ_next    = succ_reg;
        full_next    = full_reg;
        size_next    = size_reg;
        unique case (state_reg)
            fcm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = kind_in;
                    target_next  = value;
                    steps_next   = fill_reg;
                    matches_next = '0;
                    if (kind_in == fcm_pkg::KIND_INSERT)
                    begin
                        done_next = 1'b1;
                        mres_next = '0;
                        succ_next = !is_full;
                        full_next = is_full;
                        fill_next = is_full ? fill_reg : fill_reg + CW'(1);
                        size_next = fcm_pkg::to_out(fill_next);
                    end
                    else if (fill_reg == '0)
                    begin
                        done_next = 1'b1;
                        mres_next = '0;
                        succ_next = 1'b0;
                        full_next = 1'b0;
                        size_next = '0;
                    end
                end
            end
            fcm_pkg::ST_WALK:
            begin
                matches_next = matches_reg + CW'(hit);
                fill_next    = fill_reg - CW'(del);
                steps_next   = steps_reg - CW'(1);
                if (last)
                begin
                    done_next = 1'b1;
                    mres_next = fcm_pkg::to_out(matches_next);
                    succ_next = (kind_reg == fcm_pkg::KIND_ERASE_ONE) && (matches_next != '0);
                    full_next = 1'b0;
                    size_next = fcm_pkg::to_out(fill_next);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg == fcm_pkg::ST_WALK);
        cmd.shift     = 1'b0;
        cmd.head_load = 1'b0;
        cmd.wr_load   = 1'b0;
        cmd.tail_idx  = fill_reg[fcm_pkg::IDX_W-1:0];
        unique case (state_reg)
            fcm_pkg::ST_IDLE:
            begin
                cmd.wr_load = accept && (kind_in == fcm_pkg::KIND_INSERT) && !is_full;
            end
            fcm_pkg::ST_WALK:
            begin
                cmd.shift     = 1'b1;
                cmd.head_load = !del;
                cmd.tail_idx  = tail_pos[fcm_pkg::IDX_W-1:0];
            end
            default:
            begin
                cmd.shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcm_pkg::ST_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        target_reg  <= target_next;
        steps_reg   <= steps_next;
        matches_reg <= matches_next;
        mres_reg    <= mres_next;
        succ_reg    <= succ_next;
        full_reg    <= full_next;
        size_reg    <= size_next;
    end

    assign done        = done_reg;
    assign matches_res = mres_reg;
    assign success     = succ_reg;
    assign full_error  = full_reg;
    assign size_after  = size_reg;

endmodule

@@ hdl/fixed_capacity_multiset_core.sv @@
// Unordered bag of up to DEPTH signed 32-bit values. A request is taken when start is high and
// busy is low; its result appears on the result ports for one cycle with done high and must be
// taken then, since the block cannot be stalled. Insert gives its result in the cycle after the
// request. Erase-one, erase-all and count walk the live entries through a chain of cells, one
// entry a cycle, with busy high throughout the walk; done is registered from the last step of
// the walk, or comes in the cycle after the request when the bag is empty.
module fixed_capacity_multiset_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic signed [31:0]          value,
    output logic                        done,
    output logic [5:0]                  matches_res,
    output logic                        success,
    output logic                        full_error,
    output logic [5:0]                  size_after
);

    fcm_pkg::chain_cmd_t        cmd;
    logic [fcm_pkg::DATA_W-1:0] cell_data [fcm_pkg::DEPTH];
    logic [fcm_pkg::DATA_W-1:0] value_u;

    assign value_u = value;

    fcm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .head        (cell_data[0]),
        .value       (value_u),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .matches_res (matches_res),
        .success     (success),
        .full_error  (full_error),
        .size_after  (size_after)
    );

    for (genvar i = 0; i < fcm_pkg::DEPTH; i++)
    begin : g_cell
        fcm_pkg::cell_ctrl_t        ctrl;
        logic [fcm_pkg::DATA_W-1:0] right;

        assign ctrl.shift     = cmd.shift;
        assign ctrl.load      = (cmd.head_load || cmd.wr_load) &&
                                (cmd.tail_idx == fcm_pkg::IDX_W'(i));
        assign ctrl.sel_value = cmd.wr_load;

        if (i == fcm_pkg::DEPTH - 1)
        begin : g_end
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cell_data[i+1];
        end

        fcm_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .right (right),
            .head  (cell_data[0]),
            .value (value_u),
            .data  (cell_data[i])
        );
    end

endmodule

@@ hdl/fcm_checker.sv @@
`include "fixed_capacity_multiset_core_assert.svh"

module fcm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         kind,
    input logic signed [31:0] value,
    input logic               done,
    input logic [5:0]         matches_res,
    input logic               success,
    input logic               full_error,
    input logic [5:0]         size_after
);

    logic [5:0] full_size;
    logic       ins_req;

    assign full_size = fcm_pkg::to_out(fcm_pkg::CNT_W'(fcm_pkg::DEPTH));
    assign ins_req   = start && !busy && (kind == fcm_pkg::KIND_INSERT);

    `FCM_ASSERT_NEXT(a_insert_done, ins_req, done)
    `FCM_ASSERT_IMPLY(a_flags_excl, done, !(success && full_error))
    `FCM_ASSERT_IMPLY(a_full_size, done && full_error, size_after == full_size && matches_res == '0)
    `FCM_ASSERT_IMPLY(a_idle_done, done, !busy)

endmodule

bind fixed_capacity_multiset_core fcm_checker u_fcm_checker (.*);
